@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ hw/rtl/xvht_pkg.sv @@
//------------------------------------------------------------------------------
// xvht_pkg
// types and constants of the xor verified hash table
//------------------------------------------------------------------------------
`default_nettype none
package xvht_pkg;
   localparam int TableDepth = 1024;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int DivCntW = 7;

   localparam logic [1:0] REQ_PROBE = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_EMPTY = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key;
      logic [63:0] info_low;
      logic [63:0] info_high;
   } req_payload_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] out_info_low;
      logic [63:0] out_info_high;
      logic [7:0]  salt_used;
   } rsp_payload_type;

   // classified job passed from front to back
   typedef struct packed {
      logic [1:0]      op;
      logic [IdxW-1:0] slot;
      logic [63:0]     key;
      logic [63:0]     info_low;
      logic [63:0]     info_high;
   } job_type;

   typedef enum logic [1:0] {
      FR_IDLE, FR_DIV, FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_WAIT, BK_CLEAR, BK_CLRWR, BK_OUT
   } back_state_type;
endpackage
`default_nettype wire

@@ hw/rtl/xvht_front.sv @@
//------------------------------------------------------------------------------
// xvht_front
// accepts requests and computes the slot with a bit-serial remainder
//------------------------------------------------------------------------------
`default_nettype none
module xvht_front import xvht_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   input  wire logic [CntW-1:0] divisor,
   output logic                 job_valid,
   input  wire logic            job_stall,
   output job_type              job
);
   front_state_type state_ff, state_in;
   req_payload_type req_ff;
   logic [63:0] quot_ff, quot_in;
   logic [CntW:0] rem_ff, rem_in;
   logic [CntW-1:0] div_ff;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [CntW:0] shifted;
   logic load;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (req_valid) state_in = FR_DIV;
         FR_DIV:  if (cnt_ff == DivCntW'(63)) state_in = FR_PUSH;
         FR_PUSH: if (!job_stall) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != FR_IDLE);
      job_valid = (state_ff == FR_PUSH);
      load = req_valid && (state_ff == FR_IDLE);
   end

   // one key bit per cycle into the remainder, msb first
   always_comb begin
      shifted = {rem_ff[CntW-1:0], quot_ff[63]};
      quot_in = {quot_ff[62:0], 1'b0};
      rem_in = shifted;
      if (shifted >= {1'b0, div_ff}) rem_in = shifted - {1'b0, div_ff};
      cnt_in = cnt_ff + DivCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (load) begin
         req_ff <= req_payload;
         quot_ff <= req_payload.key;
         rem_ff <= '0;
         cnt_ff <= '0;
         if (divisor == '0) div_ff <= CntW'(1);
         else if (divisor > CntW'(TableDepth)) div_ff <= CntW'(TableDepth);
         else div_ff <= divisor;
      end else if (state_ff == FR_DIV) begin
         quot_ff <= quot_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      job.op = req_ff.req_type;
      job.slot = rem_ff[IdxW-1:0];
      job.key = req_ff.key;
      job.info_low = req_ff.info_low;
      job.info_high = req_ff.info_high;
   end
endmodule
`default_nettype wire

@@ hw/rtl/xvht_queue.sv @@
//------------------------------------------------------------------------------
// xvht_queue
// two-entry queue between front and back
//------------------------------------------------------------------------------
`default_nettype none
module xvht_queue import xvht_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_stall,
   output job_type      out_job
);
   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_stall = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule
`default_nettype wire

@@ hw/rtl/xvht_back.sv @@
//------------------------------------------------------------------------------
// xvht_back
// table memories, probe, write and clear sweep, result register
//------------------------------------------------------------------------------
`default_nettype none
module xvht_back import xvht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_stall,
   input  wire job_type     job,
   input  wire logic [7:0]  empty_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_payload_type  rsp_payload
);
   logic [63:0] chk_mem [TableDepth];
   logic [63:0] lo_mem [TableDepth];
   logic [63:0] hi_mem [TableDepth];
   logic [63:0] chk_rd_ff, lo_rd_ff, hi_rd_ff;
   back_state_type state_ff, state_in;
   job_type job_ff;
   logic [IdxW-1:0] addr_ff;
   logic [7:0] salt_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic [63:0] salted_hi;
   logic take, wr_en, clr_wr, last;
   logic [IdxW-1:0] rd_addr;

   assign take = job_valid && (state_ff == BK_IDLE);
   assign last = (addr_ff == IdxW'(TableDepth - 1));
   assign salted_hi = {job_ff.info_high[63:8], salt_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (job_valid) state_in = (job.op == REQ_CLEAR) ? BK_CLEAR :
                                             (job.op == REQ_PROBE) ? BK_READ : BK_OUT;
         BK_READ:  state_in = BK_WAIT;
         BK_WAIT:  state_in = BK_OUT;
         BK_CLEAR: state_in = BK_CLRWR;
         BK_CLRWR: state_in = last ? BK_OUT : BK_CLEAR;
         BK_OUT:   if (!rsp_valid || !rsp_stall) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_stall = (state_ff != BK_IDLE);
      wr_en = (state_ff == BK_OUT) && (job_ff.op == REQ_WRITE) && (!rsp_valid || !rsp_stall);
      clr_wr = (state_ff == BK_CLRWR);
      rd_addr = (state_ff == BK_CLEAR) ? addr_ff : job_ff.slot;
      rsp_in = '0;
      case (job_ff.op)
         REQ_PROBE: begin
            rsp_in.hit = (chk_rd_ff == (job_ff.key ^ lo_rd_ff ^ hi_rd_ff));
            rsp_in.out_info_low = lo_rd_ff;
            rsp_in.out_info_high = hi_rd_ff;
         end
         REQ_WRITE: rsp_in.salt_used = salt_ff;
         default: rsp_in = '0;
      endcase
   end

   // memories: read registered, clear is read-modify-write of the low word
   always_ff @(posedge clock) begin
      chk_rd_ff <= chk_mem[rd_addr];
      lo_rd_ff <= lo_mem[rd_addr];
      hi_rd_ff <= hi_mem[rd_addr];
      if (wr_en) begin
         chk_mem[job_ff.slot] <= job_ff.key ^ job_ff.info_low ^ salted_hi;
         lo_mem[job_ff.slot] <= job_ff.info_low;
         hi_mem[job_ff.slot] <= salted_hi;
      end else if (clr_wr) begin
         lo_mem[addr_ff] <= {lo_rd_ff[63:8], empty_code};
      end
   end

   // control and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         salt_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) salt_ff <= salt_ff + 8'd1;
         if (state_ff == BK_OUT && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
      if (take) begin
         job_ff <= job;
         addr_ff <= '0;
      end else if (clr_wr) begin
         addr_ff <= addr_ff + IdxW'(1);
      end
      if (state_ff == BK_OUT && (!rsp_valid || !rsp_stall)) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

@@ hw/rtl/xor_verified_hash_table.sv @@
//------------------------------------------------------------------------------
// xor_verified_hash_table
// direct-mapped table of 64-bit keys with xor-checked 128-bit info
//------------------------------------------------------------------------------
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_payload_type
// rsp      out        rsp_valid/rsp_stall   rsp_payload_type
// csr      in         csr_wr_en             csr_index, csr_data
//
// the front takes a new request only after the 64-step serial remainder of the
// key is done and its job is pushed to the queue; the back part overlaps the next
// division. clear sweeps every entry, a read-modify-write of the low word memory.
// reset is synchronous; table contents stay unknown until written.
// a stalled response holds; the queue keeps the front dividing until it is full.
`default_nettype none
`include "assert_macros.svh"
module xor_verified_hash_table import xvht_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [10:0]     csr_index,
   input  wire logic [10:0]     csr_data
);
   logic [CntW-1:0] entries_ff;
   logic [7:0] empty_ff;
   logic fq_valid, fq_stall, qb_valid, qb_stall;
   job_type fq_job, qb_job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CntW'(TableDepth);
         empty_ff <= 8'hff;
      end else if (csr_wr_en && csr_index[10:1] == '0) begin
         if (csr_index[0] == CSR_ENTRIES) entries_ff <= csr_data[CntW-1:0];
         else empty_ff <= csr_data[7:0];
      end
   end

   xvht_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .divisor(entries_ff), .job_valid(fq_valid), .job_stall(fq_stall), .job(fq_job)
   );

   xvht_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_stall(fq_stall), .in_job(fq_job),
      .out_valid(qb_valid), .out_stall(qb_stall), .out_job(qb_job)
   );

   xvht_back u_back (
      .clock, .reset, .job_valid(qb_valid), .job_stall(qb_stall), .job(qb_job),
      .empty_code(empty_ff), .rsp_valid, .rsp_stall, .rsp_payload
   );

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `ASSERT_IMPLIES(a_slot_range, clock, reset, fq_valid, fq_job.slot < entries_ff || entries_ff == '0 || entries_ff > CntW'(TableDepth))
   `ASSERT_IMPLIES(a_salt_only_write, clock, reset, rsp_valid && rsp_payload.hit, rsp_payload.salt_used == 8'd0)
endmodule
`default_nettype wire
